// ----- rtl/wgfc_pkg.sv -----
`default_nettype none

package wgfc_pkg;

	localparam int FLOW_SLOTS = 1024;
	localparam int SLOT_W     = $clog2(FLOW_SLOTS);
	localparam int DATA_PAD   = 16;
	localparam int DATA_PAD_W = $clog2(DATA_PAD);

	localparam logic [7:0] MSG_HANDSHAKE_INIT = 8'd1;
	localparam logic [7:0] MSG_HANDSHAKE_RESP = 8'd2;
	localparam logic [7:0] MSG_COOKIE_REPLY   = 8'd3;
	localparam logic [7:0] MSG_TRANSPORT_DATA = 8'd4;

	localparam logic [31:0] DNS_LOOKALIKE = 32'h0000_0100;
	localparam logic [6:0]  CONF_NONE     = 7'd0;
	localparam logic [6:0]  CONF_LOW      = 7'd1;
	localparam logic [6:0]  CONF_HIGH     = 7'd100;

	localparam logic [15:0] INIT_LENGTH_RST     = 16'd148;
	localparam logic [15:0] RESPONSE_LENGTH_RST = 16'd92;
	localparam logic [15:0] COOKIE_LENGTH_RST   = 16'd64;
	localparam logic [15:0] MIN_DATA_LENGTH_RST = 16'd32;

	typedef enum logic [1:0] {
		REG_INIT_LENGTH     = 2'd0,
		REG_RESPONSE_LENGTH = 2'd1,
		REG_COOKIE_LENGTH   = 2'd2,
		REG_MIN_DATA_LENGTH = 2'd3
	} wgfc_reg_t;

	typedef struct packed {
		logic [9:0]  flow_slot;
		logic        new_flow;
		logic        is_udp;
		logic [7:0]  msg_type;
		logic [23:0] reserved_bytes;
		logic [31:0] first_index;
		logic [31:0] second_index;
		logic [15:0] payload_length;
		logic        from_source;
	} wgfc_in_t;

	typedef struct packed {
		logic        detected;
		logic        flush_request;
		logic [6:0]  confidence;
		logic [31:0] source_peer;
		logic [31:0] dest_peer;
	} wgfc_out_t;

	typedef struct packed {
		logic [6:0]  confidence;
		logic [31:0] source_peer;
		logic [31:0] dest_peer;
	} wgfc_entry_t;

endpackage

`default_nettype wire

// ----- rtl/wireguard_flow_classifier.sv -----
// WireGuard flow classifier.
// A packet summary is presented on item and taken at a rising edge with start
// high and busy low. The flow record of item.flow_slot is read from an on-chip
// flow memory, checked and updated, and written back. The result of each
// transaction appears on result with done high for exactly one cycle. The
// packet and its record are registered at the accepting edge, and result and
// done after the check. The receiver cannot stall: a result that is not taken
// in its cycle is gone. A new packet is not taken while one is in flight. The
// flow memory has a registered read port, so each packet has a read step and
// then a check and write-back step, and busy stays high through the latter so
// that the next packet reads the record only after it was written.
// After reset the block sweeps the flow memory once, clearing one record per
// cycle, all 1024 records, with busy held high. The length registers return
// to their defaults at reset and are written through cfg_we, cfg_index and
// cfg_wdata at any time, including during the sweep, but should change only
// while the block is idle.
`default_nettype none

module wireguard_flow_classifier
	import wgfc_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire wgfc_in_t          item,
	output logic                   done,
	output wgfc_out_t              result,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_wdata
);

	wgfc_entry_t flow_mem [FLOW_SLOTS];

	logic [15:0] init_length_q;
	logic [15:0] response_length_q;
	logic [15:0] cookie_length_q;
	logic [15:0] min_data_length_q;

	logic              clearing_q;
	logic [SLOT_W-1:0] clear_ptr_q;
	logic              valid_s1;
	wgfc_in_t          item_s1;
	wgfc_entry_t       rdata_s1;

	logic              accept;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	wgfc_entry_t       mem_wdata;

	wgfc_entry_t held;
	wgfc_entry_t updated;
	wgfc_entry_t next_entry;
	logic [31:0] held_peer;
	logic        pass;
	logic        flush;
	logic        detected;

	assign accept = start && !busy;
	assign busy   = clearing_q || valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_length_q     <= INIT_LENGTH_RST;
			response_length_q <= RESPONSE_LENGTH_RST;
			cookie_length_q   <= COOKIE_LENGTH_RST;
			min_data_length_q <= MIN_DATA_LENGTH_RST;
		end else if (cfg_we) begin
			unique case (wgfc_reg_t'(cfg_index))
				REG_INIT_LENGTH:     init_length_q     <= cfg_wdata;
				REG_RESPONSE_LENGTH: response_length_q <= cfg_wdata;
				REG_COOKIE_LENGTH:   cookie_length_q   <= cfg_wdata;
				REG_MIN_DATA_LENGTH: min_data_length_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q  <= 1'b1;
			clear_ptr_q <= '0;
		end else if (clearing_q) begin
			clear_ptr_q <= clear_ptr_q + 1'b1;
			if (clear_ptr_q == SLOT_W'(FLOW_SLOTS - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			done     <= 1'b0;
		end else begin
			valid_s1 <= accept;
			done     <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item;
		end
		if (valid_s1) begin
			result.detected      <= detected;
			result.flush_request <= flush;
			result.confidence    <= next_entry.confidence;
			result.source_peer   <= next_entry.source_peer;
			result.dest_peer     <= next_entry.dest_peer;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata_s1 <= flow_mem[item.flow_slot[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			flow_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_comb begin
		held = item_s1.new_flow ? '0 : rdata_s1;
		updated = held;
		updated.confidence = (item_s1.first_index == DNS_LOOKALIKE) ? CONF_LOW : CONF_HIGH;
		held_peer = item_s1.from_source ? held.source_peer : held.dest_peer;
		flush = 1'b0;
		pass = (item_s1.payload_length >= min_data_length_q) && (item_s1.reserved_bytes == '0);

		case (item_s1.msg_type)
			MSG_HANDSHAKE_INIT: begin
				pass = pass && (item_s1.payload_length == init_length_q);
				if (item_s1.from_source) begin
					updated.source_peer = item_s1.first_index;
				end else begin
					updated.dest_peer = item_s1.first_index;
				end
				flush = pass && (held_peer != '0) && (held_peer != item_s1.first_index);
			end
			MSG_HANDSHAKE_RESP: begin
				pass = pass && (item_s1.payload_length == response_length_q);
				if (item_s1.from_source) begin
					updated.source_peer = item_s1.first_index;
					updated.dest_peer   = item_s1.second_index;
				end else begin
					updated.source_peer = item_s1.second_index;
					updated.dest_peer   = item_s1.first_index;
				end
			end
			MSG_COOKIE_REPLY: begin
				pass = pass && (item_s1.payload_length == cookie_length_q);
				if (item_s1.from_source) begin
					updated.dest_peer = item_s1.first_index;
				end else begin
					updated.source_peer = item_s1.first_index;
				end
			end
			MSG_TRANSPORT_DATA: begin
				pass = pass && (item_s1.payload_length[DATA_PAD_W-1:0] == '0);
				if (item_s1.from_source) begin
					updated.dest_peer = item_s1.first_index;
				end else begin
					updated.source_peer = item_s1.first_index;
				end
			end
			default: begin
				pass = 1'b0;
			end
		endcase

		detected   = 1'b0;
		next_entry = held;
		if (item_s1.new_flow) begin
			flush = 1'b0;
			if (item_s1.is_udp && pass) begin
				detected   = 1'b1;
				next_entry = updated;
			end
		end else if (held.confidence != CONF_NONE) begin
			if (flush) begin
				next_entry = held;
			end else if (pass) begin
				detected   = 1'b1;
				next_entry = updated;
			end else begin
				next_entry.confidence = CONF_NONE;
			end
		end else begin
			flush = 1'b0;
		end

		mem_we    = clearing_q || valid_s1;
		mem_waddr = clearing_q ? clear_ptr_q : item_s1.flow_slot[SLOT_W-1:0];
		mem_wdata = clearing_q ? '0 : next_entry;
	end

	a_accept_interlock: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !accept)
		else $error("packet accepted while a flow record update is pending");

	a_result_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##2 done)
		else $error("result strobe missing two cycles after a transaction");

	a_detect_or_flush: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(result.detected && result.flush_request))
		else $error("result both detected and flush requested");

	a_flush_keeps_conf: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.flush_request |-> result.confidence != CONF_NONE)
		else $error("flush requested on a flow with no confidence");

	a_detect_conf: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.detected |->
			(result.confidence == CONF_LOW || result.confidence == CONF_HIGH))
		else $error("detected packet with unexpected confidence");

endmodule

`default_nettype wire

// ----- tb/wireguard_flow_classifier_tb.sv -----
module wireguard_flow_classifier_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wgfc_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int IDLE_PCT = 29;

	typedef enum logic [1:0] {
		VERDICT_REJECT,
		VERDICT_ACCEPT,
		VERDICT_FLUSH
	} verdict_t;

	typedef struct {
		bit        typed;
		wgfc_in_t  pkt;
		wgfc_out_t want;
	} stim_row_t;

	localparam wgfc_out_t CLEARED = '0;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	wgfc_in_t    item = '0;
	logic        done;
	wgfc_out_t   result;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_wdata = '0;

	logic [31:0] peer_src [FLOW_SLOTS];
	logic [31:0] peer_dst [FLOW_SLOTS];
	logic [6:0]  flow_conf [FLOW_SLOTS];
	bit          flow_opened [FLOW_SLOTS];
	logic [15:0] length_reg [4];
	wgfc_out_t   expected_results [$];
	int unsigned slot_pool [12];
	int          error_count = 0;
	int          item_count = 0;
	int          cycle_count = 0;

	stim_row_t directed_rows [23] = '{
		'{1'b1, '{10'd0, 1'b1, 1'b1, MSG_HANDSHAKE_INIT, 24'd0, 32'h1122_3344, 32'd0,
			INIT_LENGTH_RST, 1'b1}, '{1'b1, 1'b0, CONF_HIGH, 32'h1122_3344, 32'd0}},
		'{1'b1, '{10'd0, 1'b0, 1'b0, MSG_HANDSHAKE_INIT, 24'd0, 32'h5566_7788, 32'd0,
			INIT_LENGTH_RST, 1'b1}, '{1'b0, 1'b1, CONF_HIGH, 32'h1122_3344, 32'd0}},
		'{1'b0, '{10'd0, 1'b0, 1'b1, MSG_HANDSHAKE_RESP, 24'd0, 32'hA5A5_0001, 32'h5A5A_0002,
			RESPONSE_LENGTH_RST, 1'b0}, CLEARED},
		'{1'b0, '{10'd0, 1'b0, 1'b1, MSG_COOKIE_REPLY, 24'd0, 32'hC0C0_0003, 32'd0,
			COOKIE_LENGTH_RST, 1'b1}, CLEARED},
		'{1'b0, '{10'd0, 1'b0, 1'b1, MSG_TRANSPORT_DATA, 24'd0, 32'hD0D0_0004, 32'd0,
			16'd48, 1'b0}, CLEARED},
		'{1'b0, '{10'd0, 1'b0, 1'b1, MSG_TRANSPORT_DATA, 24'd0, 32'h0000_0001, 32'd0,
			16'd40, 1'b1}, CLEARED},
		'{1'b0, '{10'd0, 1'b0, 1'b1, MSG_HANDSHAKE_INIT, 24'd0, 32'h1122_3344, 32'd0,
			INIT_LENGTH_RST, 1'b1}, CLEARED},
		'{1'b1, '{10'd1023, 1'b1, 1'b0, MSG_HANDSHAKE_INIT, 24'd0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, INIT_LENGTH_RST, 1'b1}, CLEARED},
		'{1'b0, '{10'd1023, 1'b0, 1'b1, MSG_TRANSPORT_DATA, 24'd0, 32'h0000_0077, 32'd0,
			16'd64, 1'b1}, CLEARED},
		'{1'b1, '{10'd1, 1'b1, 1'b1, 8'h00, 24'd0, 32'h0000_0010, 32'd0,
			INIT_LENGTH_RST, 1'b1}, CLEARED},
		'{1'b1, '{10'd2, 1'b1, 1'b1, 8'hFF, 24'd0, 32'h0000_0010, 32'd0,
			INIT_LENGTH_RST, 1'b0}, CLEARED},
		'{1'b1, '{10'd3, 1'b1, 1'b1, 8'h05, 24'd0, 32'h0000_0010, 32'd0,
			16'd64, 1'b1}, CLEARED},
		'{1'b1, '{10'd4, 1'b1, 1'b1, MSG_HANDSHAKE_INIT, 24'hFF_FFFF, 32'h0000_0001, 32'd0,
			INIT_LENGTH_RST, 1'b1}, CLEARED},
		'{1'b1, '{10'd5, 1'b1, 1'b1, MSG_TRANSPORT_DATA, 24'd0, 32'h0000_0009, 32'd0,
			16'd16, 1'b0}, CLEARED},
		'{1'b1, '{10'd6, 1'b1, 1'b1, MSG_TRANSPORT_DATA, 24'd0, DNS_LOOKALIKE, 32'hFFFF_FFFF,
			16'hFFF0, 1'b1}, '{1'b1, 1'b0, CONF_LOW, 32'd0, DNS_LOOKALIKE}},
		'{1'b1, '{10'd7, 1'b1, 1'b1, MSG_HANDSHAKE_RESP, 24'd0, 32'hFFFF_FFFF, 32'd0,
			RESPONSE_LENGTH_RST, 1'b1}, '{1'b1, 1'b0, CONF_HIGH, 32'hFFFF_FFFF, 32'd0}},
		'{1'b0, '{10'd7, 1'b0, 1'b1, MSG_HANDSHAKE_INIT, 24'd0, 32'hDEAD_BEEF, 32'd0,
			INIT_LENGTH_RST, 1'b0}, CLEARED},
		'{1'b0, '{10'd7, 1'b0, 1'b1, MSG_HANDSHAKE_INIT, 24'd0, 32'hDEAD_BEEF, 32'd0,
			INIT_LENGTH_RST, 1'b0}, CLEARED},
		'{1'b0, '{10'd6, 1'b0, 1'b1, MSG_HANDSHAKE_INIT, 24'd0, 32'h2468_ACE0, 32'd0,
			INIT_LENGTH_RST, 1'b1}, CLEARED},
		'{1'b0, '{10'd8, 1'b1, 1'b1, MSG_COOKIE_REPLY, 24'd0, 32'hFFFF_FFFF, 32'd0,
			COOKIE_LENGTH_RST, 1'b0}, CLEARED},
		'{1'b1, '{10'd512, 1'b1, 1'b1, MSG_HANDSHAKE_INIT, 24'd0, 32'd0, 32'd0,
			INIT_LENGTH_RST, 1'b0}, '{1'b1, 1'b0, CONF_HIGH, 32'd0, 32'd0}},
		'{1'b0, '{10'd512, 1'b0, 1'b1, MSG_HANDSHAKE_INIT, 24'd0, DNS_LOOKALIKE, 32'd0,
			INIT_LENGTH_RST, 1'b0}, CLEARED},
		'{1'b0, '{10'd8, 1'b0, 1'b1, MSG_TRANSPORT_DATA, 24'd0, 32'h0000_0003, 32'd0,
			16'hFFFF, 1'b1}, CLEARED}
	};

	wireguard_flow_classifier dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** wireguard_flow_classifier: FAILED **");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	always @(posedge clk) begin
		wgfc_out_t want;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with no transaction pending");
			end else begin
				want = expected_results.pop_front();
				check_field("detected", 32'(result.detected), 32'(want.detected));
				check_field("flush_request", 32'(result.flush_request),
					32'(want.flush_request));
				check_field("confidence", 32'(result.confidence), 32'(want.confidence));
				check_field("source_peer", result.source_peer, want.source_peer);
				check_field("dest_peer", result.dest_peer, want.dest_peer);
			end
		end
	end

	// Updates the flow record of the packet's slot and returns the result that it causes.
	function automatic wgfc_out_t classify_packet(input wgfc_in_t p);
		wgfc_out_t r;
		verdict_t verdict;
		logic [9:0] s;
		logic [31:0] held;
		logic checked;
		s = p.flow_slot;
		r = '0;
		if (p.new_flow) begin
			peer_src[s] = '0;
			peer_dst[s] = '0;
			flow_conf[s] = CONF_NONE;
			flow_opened[s] = 1'b1;
		end
		checked = p.new_flow ? p.is_udp : (flow_conf[s] != CONF_NONE);
		if (checked) begin
			verdict = VERDICT_ACCEPT;
			held = p.from_source ? peer_src[s] : peer_dst[s];
			if (p.payload_length < length_reg[REG_MIN_DATA_LENGTH] || p.reserved_bytes != '0)
				verdict = VERDICT_REJECT;
			else begin
				case (p.msg_type)
					MSG_HANDSHAKE_INIT: begin
						if (p.payload_length != length_reg[REG_INIT_LENGTH])
							verdict = VERDICT_REJECT;
						else if (held != '0 && held != p.first_index)
							verdict = VERDICT_FLUSH;
					end
					MSG_HANDSHAKE_RESP: begin
						if (p.payload_length != length_reg[REG_RESPONSE_LENGTH])
							verdict = VERDICT_REJECT;
					end
					MSG_COOKIE_REPLY: begin
						if (p.payload_length != length_reg[REG_COOKIE_LENGTH])
							verdict = VERDICT_REJECT;
					end
					MSG_TRANSPORT_DATA: begin
						if ((p.payload_length % DATA_PAD) != 0)
							verdict = VERDICT_REJECT;
					end
					default: verdict = VERDICT_REJECT;
				endcase
			end
			case (verdict)
				VERDICT_ACCEPT: begin
					case (p.msg_type)
						MSG_HANDSHAKE_INIT: begin
							if (p.from_source)
								peer_src[s] = p.first_index;
							else
								peer_dst[s] = p.first_index;
						end
						MSG_HANDSHAKE_RESP: begin
							peer_src[s] = p.from_source ? p.first_index : p.second_index;
							peer_dst[s] = p.from_source ? p.second_index : p.first_index;
						end
						default: begin
							if (p.from_source)
								peer_dst[s] = p.first_index;
							else
								peer_src[s] = p.first_index;
						end
					endcase
					flow_conf[s] = (p.first_index == DNS_LOOKALIKE) ? CONF_LOW : CONF_HIGH;
					r.detected = 1'b1;
				end
				VERDICT_FLUSH: r.flush_request = 1'b1;
				default: flow_conf[s] = CONF_NONE;
			endcase
		end
		r.confidence = flow_conf[s];
		r.source_peer = peer_src[s];
		r.dest_peer = peer_dst[s];
		return r;
	endfunction

	function automatic wgfc_in_t make_packet();
		wgfc_in_t p;
		int unsigned lo;
		p.flow_slot = SLOT_W'(($urandom_range(0, 99) < 70) ? slot_pool[$urandom_range(0, 11)]
			: $urandom_range(0, FLOW_SLOTS - 1));
		p.new_flow = !flow_opened[p.flow_slot] || ($urandom_range(0, 99) < 12);
		p.is_udp = $urandom_range(0, 99) < 90;
		p.msg_type = 8'(($urandom_range(0, 99) < 85) ? $urandom_range(1, 4) : $urandom);
		p.reserved_bytes = ($urandom_range(0, 99) < 88) ? 24'd0
			: 24'($urandom_range(1, 24'hFF_FFFF));
		p.from_source = 1'($urandom_range(0, 1));
		p.second_index = $urandom;
		if ($urandom_range(0, 99) < 10)
			p.first_index = DNS_LOOKALIKE;
		else if (p.msg_type == MSG_HANDSHAKE_INIT && !p.new_flow && $urandom_range(0, 99) < 60)
			p.first_index = p.from_source ? peer_src[p.flow_slot] : peer_dst[p.flow_slot];
		else
			p.first_index = $urandom;
		p.payload_length = 16'($urandom_range(0, 16'hFFFF));
		if ($urandom_range(0, 99) < 85) begin
			case (p.msg_type)
				MSG_HANDSHAKE_INIT: p.payload_length = length_reg[REG_INIT_LENGTH];
				MSG_HANDSHAKE_RESP: p.payload_length = length_reg[REG_RESPONSE_LENGTH];
				MSG_COOKIE_REPLY: p.payload_length = length_reg[REG_COOKIE_LENGTH];
				MSG_TRANSPORT_DATA: begin
					lo = (length_reg[REG_MIN_DATA_LENGTH] + DATA_PAD - 1) / DATA_PAD;
					if (lo <= 16'hFFFF / DATA_PAD)
						p.payload_length = 16'(DATA_PAD
							* $urandom_range(lo, 16'hFFFF / DATA_PAD));
				end
				default: ;
			endcase
		end
		return p;
	endfunction

	task automatic send_packet(input wgfc_in_t p, input bit typed, input wgfc_out_t want);
		wgfc_out_t predicted;
		if ((item_count < 250 || item_count >= 330) && $urandom_range(0, 99) < IDLE_PCT) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		item <= p;
		do @(posedge clk); while (busy);
		predicted = classify_packet(p);
		expected_results.push_back(typed ? want : predicted);
		item_count++;
	endtask

	task automatic run_random(input int count);
		repeat (count) send_packet(make_packet(), 1'b0, CLEARED);
	endtask

	task automatic wait_quiet();
		start <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input wgfc_reg_t idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		length_reg[idx] = value;
	endtask

	task automatic set_lengths(input logic [15:0] init_len, input logic [15:0] resp_len,
			input logic [15:0] cookie_len, input logic [15:0] min_len);
		wait_quiet();
		write_reg(REG_INIT_LENGTH, init_len);
		write_reg(REG_RESPONSE_LENGTH, resp_len);
		write_reg(REG_COOKIE_LENGTH, cookie_len);
		write_reg(REG_MIN_DATA_LENGTH, min_len);
		cfg_we <= 1'b0;
	endtask

	initial begin
		for (int i = 0; i < FLOW_SLOTS; i++) begin
			peer_src[i] = '0;
			peer_dst[i] = '0;
			flow_conf[i] = CONF_NONE;
			flow_opened[i] = 1'b0;
		end
		length_reg[REG_INIT_LENGTH] = INIT_LENGTH_RST;
		length_reg[REG_RESPONSE_LENGTH] = RESPONSE_LENGTH_RST;
		length_reg[REG_COOKIE_LENGTH] = COOKIE_LENGTH_RST;
		length_reg[REG_MIN_DATA_LENGTH] = MIN_DATA_LENGTH_RST;
		foreach (slot_pool[i])
			slot_pool[i] = $urandom_range(0, FLOW_SLOTS - 1);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_packet(directed_rows[i].pkt, directed_rows[i].typed, directed_rows[i].want);

		run_random(150);
		set_lengths(16'd0, 16'd0, 16'd0, 16'd0);
		run_random(100);
		set_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(80);
		set_lengths(16'($urandom_range(0, 200)), 16'($urandom_range(0, 200)),
			16'($urandom_range(0, 200)), 16'($urandom_range(0, 64)));
		run_random(120);
		set_lengths(INIT_LENGTH_RST, RESPONSE_LENGTH_RST, COOKIE_LENGTH_RST,
			MIN_DATA_LENGTH_RST);
		run_random(100);

		wait_quiet();
		repeat (8) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
		if (error_count == 0) begin
			$display("** wireguard_flow_classifier: PASSED **");
		end else begin
			$display("** wireguard_flow_classifier: FAILED **");
		end
		$finish;
	end

endmodule
